/* sv/stream_find_replace_assert.svh */
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sfr_pkg.sv */
package sfr_pkg;

  localparam int PATTERN_BYTES_DEF = 8;
  localparam int MAX_BYTES         = 8;
  localparam int IDX_W             = $clog2(MAX_BYTES);
  localparam int LEN_W             = 4;
  localparam int CNT_W             = 16;
  localparam int CFG_W             = 64;
  localparam int CFG_IDX_W         = 2;
  localparam int QUEUE_DEPTH       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_PATTERN  = 2'd0,
    CFG_SEARCH_LENGTH   = 2'd1,
    CFG_REPLACE_PATTERN = 2'd2,
    CFG_REPLACE_LENGTH  = 2'd3
  } cfg_reg_t;

  // one burst of results: cnt data bytes, then a final item when fin is set
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          cnt;
    logic                      fin;
    logic [CNT_W-1:0]          total;
  } sfr_desc_t;

endpackage

/* sv/stream_find_replace.sv */
// Streaming find-and-replace on bytes. Each accepted data byte is judged in
// the same cycle against the search pattern; the front end turns it into a
// burst (pass-through bytes, the replacement, or, on an end item, the held
// window plus a final count item) and puts it in a 4-entry queue. The back
// end sends one result per cycle while out_stall is low, a transfer after the
// cycle of acceptance at the earliest. Plain text thus streams at one byte
// per cycle; an item giving k results holds the output port for k transfers,
// and the queue lets the input keep moving until four bursts are waiting,
// after which in_stall rises. Configuration must be written by the user
// with cfg_we only while the stream is idle; the block does not enforce it.
`include "stream_find_replace_assert.svh"

module stream_find_replace import sfr_pkg::*; #(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 byte_valid,
  output logic                 end_mark,
  output logic [CNT_W-1:0]     match_total
);

  sfr_desc_t desc;
  sfr_desc_t head;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;

  sfr_front #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .desc     (desc)
  );

  sfr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_desc(desc),
    .pop    (pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .end_mark   (end_mark),
    .match_total(match_total)
  );

  `SFR_ASSERT_NOW(a_end_queued, in_valid && !in_stall && action, push && desc.fin, "end item not queued")
  `SFR_ASSERT_NOW(a_burst_len, push, desc.cnt <= LEN_W'(PATTERN_BYTES), "burst longer than window")
  `SFR_ASSERT_NOW(a_pop_on_xfer, pop, out_valid && !out_stall, "queue popped without transfer")
  `SFR_ASSERT_NEXT(a_push_lands, push && !pop, !q_empty, "pushed burst missing")

endmodule

/* sv/sfr_front.sv */
module sfr_front import sfr_pkg::*; #(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [7:0]           in_byte,
  input  logic                 q_full,
  output logic                 push,
  output sfr_desc_t            desc
);

  localparam int FW = $clog2(PATTERN_BYTES + 1);
  localparam int CW = LEN_W + 1;

  logic [CFG_W-1:0] search_pattern;
  logic [LEN_W-1:0] search_length;
  logic [CFG_W-1:0] replace_pattern;
  logic [LEN_W-1:0] replace_length;

  logic [7:0]       win [PATTERN_BYTES];
  logic [FW-1:0]    fill;
  logic [CNT_W-1:0] match_counter;

  logic [7:0]               wb   [PATTERN_BYTES];
  logic [7:0]               nwin [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] eq   [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] cand;
  logic [LEN_W-1:0]         sl;
  logic [LEN_W-1:0]         rl;
  logic [CW-1:0]            sl5;
  logic [CW-1:0]            n5;
  logic [FW-1:0]            n;
  logic [FW-1:0]            shift;
  logic                     full_match;
  logic                     accept;
  logic [FW-1:0]            fill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern  <= '0;
      search_length   <= '0;
      replace_pattern <= '0;
      replace_length  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SEARCH_PATTERN:  search_pattern  <= cfg_data;
        CFG_SEARCH_LENGTH:   search_length   <= cfg_data[LEN_W-1:0];
        CFG_REPLACE_PATTERN: replace_pattern <= cfg_data;
        CFG_REPLACE_LENGTH:  replace_length  <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  assign sl  = (search_length > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES) : search_length;
  assign rl  = (replace_length > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES)
                                                         : replace_length;
  assign sl5 = CW'(sl);
  assign n   = fill + FW'(1);
  assign n5  = CW'(n);

  always_comb begin
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      wb[i] = (FW'(i) == fill) ? in_byte : win[i];
    end
  end

  for (genvar gs = 0; gs < PATTERN_BYTES; gs++) begin : g_s
    for (genvar gj = 0; gj < PATTERN_BYTES; gj++) begin : g_j
      if (gs + gj < PATTERN_BYTES) begin : g_cmp
        assign eq[gs][gj] = (wb[gs+gj] == search_pattern[8*gj +: 8]);
      end else begin : g_pad
        assign eq[gs][gj] = 1'b0;
      end
    end
  end

  // full match, and the first start whose tail is still a pattern prefix
  always_comb begin
    full_match = (sl != '0) && (n5 == sl5);
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      if (CW'(j) < sl5 && !eq[0][j]) full_match = 1'b0;
    end
    for (int s = 0; s < PATTERN_BYTES; s++) begin
      cand[s] = (CW'(s) < n5) && (n5 < sl5 + CW'(s));
      for (int j = 0; j < PATTERN_BYTES; j++) begin
        if (CW'(s + j) < n5 && !eq[s][j]) cand[s] = 1'b0;
      end
    end
    shift = n;
    for (int s = PATTERN_BYTES - 1; s >= 0; s--) begin
      if (cand[s]) shift = FW'(s);
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      nwin[i] = wb[i];
      for (int k = 0; k < PATTERN_BYTES; k++) begin
        if (CW'(k) == CW'(i) + CW'(shift)) nwin[i] = wb[k];
      end
    end
  end

  always_comb begin
    desc.bytes = '0;
    desc.cnt   = '0;
    desc.fin   = 1'b0;
    desc.total = '0;
    fill_next  = fill;
    if (action) begin
      for (int i = 0; i < PATTERN_BYTES; i++) desc.bytes[i] = win[i];
      desc.cnt   = LEN_W'(fill);
      desc.fin   = 1'b1;
      desc.total = match_counter;
      fill_next  = '0;
    end else if (full_match) begin
      desc.bytes = replace_pattern;
      desc.cnt   = rl;
      fill_next  = '0;
    end else begin
      for (int i = 0; i < PATTERN_BYTES; i++) desc.bytes[i] = wb[i];
      desc.cnt  = LEN_W'(shift);
      fill_next = n - shift;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (desc.fin || desc.cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      match_counter <= '0;
    end else if (accept) begin
      fill <= fill_next;
      if (action) begin
        match_counter <= '0;
      end else if (full_match && match_counter != '1) begin
        match_counter <= match_counter + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !action) begin
      for (int i = 0; i < PATTERN_BYTES; i++) win[i] <= nwin[i];
    end
  end

endmodule

/* sv/sfr_queue.sv */
module sfr_queue import sfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  sfr_desc_t wr_desc,
  input  logic      pop,
  output sfr_desc_t head,
  output logic      full,
  output logic      empty
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  sfr_desc_t     slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == NW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QW'(1);
      if (do_pop) rd_ptr <= rd_ptr + QW'(1);
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_desc;
  end

endmodule

/* sv/sfr_back.sv */
module sfr_back import sfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  sfr_desc_t        head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             end_mark,
  output logic [CNT_W-1:0] match_total
);

  logic [LEN_W-1:0] idx;
  logic             is_byte;
  logic             last;
  logic             xfer;

  assign is_byte     = (idx < head.cnt);
  assign last        = is_byte ? (!head.fin && (idx + LEN_W'(1) == head.cnt)) : 1'b1;
  assign out_valid   = !empty;
  assign xfer        = out_valid && !out_stall;
  assign pop         = xfer && last;
  assign out_byte    = is_byte ? head.bytes[idx[IDX_W-1:0]] : 8'h00;
  assign byte_valid  = is_byte;
  assign end_mark    = !is_byte;
  assign match_total = is_byte ? '0 : head.total;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= last ? '0 : idx + LEN_W'(1);
    end
  end

endmodule
